// File: rtl/lrrle_pkg.sv
// Types, constants and helpers for the row run-length encoder.
package lrrle_pkg;

    localparam int COLOR_COUNT = 16;
    localparam int COLOR_W     = $clog2(COLOR_COUNT);
    localparam int MAX_SIDE    = 4096;
    localparam int POS_W       = $clog2(MAX_SIDE);   // column / row index
    localparam int LEN_W       = POS_W + 1;          // run length, up to MAX_SIDE
    localparam int CFG_W       = 13;
    localparam int SITE_W      = 32;

    // register indexes
    localparam logic CFG_ROW_WIDTH = 1'b0;
    localparam logic CFG_ROW_COUNT = 1'b1;

    typedef struct packed {
        logic               frame_end;
        logic               last_of_item;
        logic               single_site;
        logic [LEN_W-1:0]   run_length;
        logic [POS_W-1:0]   row_number;
        logic [POS_W-1:0]   start_column;
        logic [COLOR_W-1:0] color_index;
    } t_run_rec;

    function automatic logic [CFG_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] r;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (v > CFG_W'(MAX_SIDE)) begin
            r = CFG_W'(MAX_SIDE);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // negative values map to 15 minus (magnitude mod 16); most negative wraps cleanly
    function automatic logic [COLOR_W-1:0] color_of(input logic [SITE_W-1:0] raw);
        logic [SITE_W-1:0] mag;
        logic [SITE_W-1:0] c;
        mag = SITE_W'(0) - raw;
        if (!raw[SITE_W-1]) begin
            c = raw % COLOR_COUNT;
        end else begin
            c = SITE_W'(COLOR_COUNT - 1) - (mag % COLOR_COUNT);
        end
        return c[COLOR_W-1:0];
    endfunction

endpackage

// File: rtl/lattice_row_run_length_encoder.sv
// Top level: row-wise run-length encoder for a window of signed site values.
//
// Sites stream in row-scan order, one beat per cycle, through an input register; a
// single compare against the open run decides what closes, and the closed runs go
// into a four-entry result queue that feeds the output port. A site that keeps a run
// going gives no beat, one that changes the value or ends a row gives one, and one
// that does both gives two (the changed run first, then the one-site run). The input
// side takes one site per cycle as long as the queue has room; the output side drains
// one run per cycle while i_m_tready is high. row_width and row_count of 0 act as 1,
// values above 4096 act as 4096; write them only while the block is idle.
module lattice_row_run_length_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [12:0] i_cfg_data,
    // site input
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] site_value
    // run output
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // [3:0] color_index, [15:4] start_column,
                                     // [27:16] row_number, [40:28] run_length, rest 0
    output logic [1:0]  o_m_tuser,   // [0] single_site, [1] last_of_item
    output logic        o_m_tlast    // frame_end
);
    import lrrle_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;
    localparam int DATA_W = COLOR_W + 2 * POS_W + LEN_W;

    // configuration
    logic [CFG_W-1:0] r_row_width, r_row_count;

    // input register
    logic              r_in_valid;
    logic [SITE_W-1:0] r_site;

    // run tracking state
    logic [SITE_W-1:0] r_run_value, n_run_value;
    logic [POS_W-1:0]  r_run_start, n_run_start;
    logic [POS_W-1:0]  r_col, n_col;
    logic [POS_W-1:0]  r_row, n_row;

    // result queue
    t_run_rec          r_fifo [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    logic              first_site, value_change, row_end, last_row, proc_fire, pop;
    logic [LEN_W-1:0]  col_inc;
    logic [1:0]        n_res;
    t_run_rec          rec_change, rec_end, rec_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= CFG_W'(1);
            r_row_count <= CFG_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROW_WIDTH: r_row_width <= clamp_side(i_cfg_data);
                CFG_ROW_COUNT: r_row_count <= clamp_side(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_comb begin
        first_site   = (r_col == '0);
        value_change = !first_site && (r_site != r_run_value);
        col_inc      = LEN_W'(r_col) + LEN_W'(1);
        row_end      = ({1'b0, col_inc} >= {1'b0, r_row_width});
        last_row     = ((LEN_W'(r_row) + LEN_W'(1)) >= r_row_count);

        n_run_value  = (first_site || value_change) ? r_site : r_run_value;
        n_run_start  = first_site ? '0 : (value_change ? r_col : r_run_start);

        rec_change.color_index  = color_of(r_run_value);
        rec_change.start_column = r_run_start;
        rec_change.row_number   = r_row;
        rec_change.run_length   = LEN_W'(r_col) - LEN_W'(r_run_start);
        rec_change.single_site  = (rec_change.run_length == LEN_W'(1));
        rec_change.last_of_item = !row_end;
        rec_change.frame_end    = 1'b0;

        rec_end.color_index  = color_of(n_run_value);
        rec_end.start_column = n_run_start;
        rec_end.row_number   = r_row;
        rec_end.run_length   = col_inc - LEN_W'(n_run_start);
        rec_end.single_site  = (rec_end.run_length == LEN_W'(1));
        rec_end.last_of_item = 1'b1;
        rec_end.frame_end    = last_row;

        rec_first = value_change ? rec_change : rec_end;
        n_res     = {1'b0, value_change} + {1'b0, row_end};

        // room is judged without this cycle's pop to keep the two sides apart
        proc_fire  = r_in_valid && ((r_count + CNT_W'(n_res)) <= CNT_W'(DEPTH));
        o_s_tready = !r_in_valid || proc_fire;
        pop        = o_m_tvalid && i_m_tready;

        if (row_end) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + POS_W'(1);
        end else begin
            n_col = col_inc[POS_W-1:0];
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_site <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_value <= '0;
            r_run_start <= '0;
            r_col       <= '0;
            r_row       <= '0;
        end else if (proc_fire) begin
            r_run_value <= n_run_value;
            r_run_start <= row_end ? '0 : n_run_start;
            r_col       <= n_col;
            r_row       <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire && n_res != 2'd0) begin
            r_fifo[r_wr_ptr] <= rec_first;
        end
        if (proc_fire && n_res == 2'd2) begin
            r_fifo[r_wr_ptr + PTR_W'(1)] <= rec_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (proc_fire) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(n_res);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + (proc_fire ? CNT_W'(n_res) : '0) - CNT_W'(pop);
        end
    end

    t_run_rec head;
    assign head       = r_fifo[r_rd_ptr];
    assign o_m_tvalid = (r_count != '0);
    assign o_m_tdata  = {(48 - DATA_W)'(0), head.run_length, head.row_number,
                         head.start_column, head.color_index};
    assign o_m_tuser  = {head.last_of_item, head.single_site};
    assign o_m_tlast  = head.frame_end;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("result queue overfilled");

    a_frame_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> o_m_tuser[1])
        else $error("frame end run is not the last run of its site");

    a_single_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser[0] == (head.run_length == LEN_W'(1))))
        else $error("single-site flag disagrees with run length");

    a_col_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_fire && row_end) |=> (r_col == '0 && r_run_start == '0))
        else $error("column state not cleared at row end");

endmodule
